[sv/h2b64_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2b64_pkg: shared types and helpers for the hex to base64 stream
// Item structs, the job record passed from front to back, status codes and
// the character mapping functions.
// ----------------------------------------------------------------------------
package h2b64_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_ODD_LEN   = 2'd2
  } status_e;

  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [7:0] ChUpF   = 8'h46;  // 'F'
  localparam logic [7:0] ChLoA   = 8'h61;  // 'a'
  localparam logic [7:0] ChLoF   = 8'h66;  // 'f'
  localparam logic [7:0] ChPlus  = 8'h2b;  // '+'
  localparam logic [7:0] ChSlash = 8'h2f;  // '/'
  localparam logic [7:0] ChPad   = 8'h3d;  // '='

  localparam logic [5:0] SxUpperEnd = 6'h1a;
  localparam logic [5:0] SxLowerEnd = 6'h34;
  localparam logic [5:0] SxDigitEnd = 6'h3e;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       end_of_run;
  } out_item_t;

  // One unit of work for the back end: either a single error result or a
  // group of four characters, of which pad trailing ones are '='.
  typedef struct packed {
    logic        is_err;
    logic [1:0]  status;
    logic [23:0] word;
    logic [1:0]  pad;
    logic        last;
  } job_t;

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h0;
    if (c inside {[ChZero:ChNine]}) begin
      t = c - ChZero;
    end else if (c inside {[ChLoA:ChLoF]}) begin
      t = c - ChLoA + 8'd10;
    end else if (c inside {[ChUpA:ChUpF]}) begin
      t = c - ChUpA + 8'd10;
    end else begin
      t = 8'h10;
    end
    return t[4:0];
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < SxUpperEnd) begin
      r = ChUpA + {2'b00, v};
    end else if (v < SxLowerEnd) begin
      r = ChLoA + {2'b00, v - SxUpperEnd};
    end else if (v < SxDigitEnd) begin
      r = ChZero + {2'b00, v - SxLowerEnd};
    end else if (v == SxDigitEnd) begin
      r = ChPlus;
    end else begin
      r = ChSlash;
    end
    return r;
  endfunction

endpackage

[sv/hex_to_base64_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_to_base64_stream: streaming ASCII hex to base64 converter
// Front end groups hex digits into 3-byte jobs, back end issues characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_i/in_data_i) takes one hex character
//   per transfer, with last_item marking the end of a string. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives one base64 character, its
//   status and an end_of_run flag per transfer.
//   Throughput: one input transfer per cycle while the job queue has room;
//   one output transfer per cycle while out_ready_i is high. Six digits
//   yield four characters, so a steady stream runs at full rate; short
//   strings with many results per digit fill the queue and drop in_ready_o
//   until the back end drains it. Path: the first result of a job goes from
//   the queue into the current-job register (job load), then into the output
//   register; the queue itself is written at the transfer edge. The back end
//   issues one character per cycle while out_ready_i is high; a
//   four-character group occupies it until its last character is taken.
//   Reset clears the digit/byte state, the queue and the output stage; no
//   results are pending afterwards. When the receiver stalls, the output
//   register holds its item and the queue absorbs up to QueueDepth jobs
//   before the input side stalls too.
// ----------------------------------------------------------------------------
module hex_to_base64_stream
  import h2b64_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  // Front to queue
  logic job_push;
  job_t job_wdata;
  logic job_full;

  // Queue to back
  logic job_valid;
  logic job_pop;
  job_t job_rdata;

  h2b64_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_wdata)
  );

  h2b64_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .valid_o (job_valid),
    .full_o  (job_full)
  );

  h2b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_rdata),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A job is never offered to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // The back end only takes jobs that exist.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

  // Error results are single, zeroed and close the run.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK)) |->
      (out_data_o.end_of_run && (out_data_o.out_char == 8'h00)))
    else $error("error result malformed");

endmodule
`default_nettype wire

[sv/h2b64_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2b64_front: character intake and grouping
// Pairs hex digits into bytes, groups bytes by three and issues one job per
// group, error or end of string.
// ----------------------------------------------------------------------------
module h2b64_front
  import h2b64_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  input  wire logic     job_full_i,
  output logic          job_push_o,
  output job_t          job_o
);

  logic [3:0]  high_nibble_q, high_nibble_d;
  logic        pending_q, pending_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  count_q, count_d;
  logic        discard_q, discard_d;

  logic        accept;
  logic [4:0]  nib;
  logic [7:0]  byte_val;
  logic        last;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign nib        = nibble_of(in_data_i.hex_char);
  assign byte_val   = {high_nibble_q, nib[3:0]};
  assign last       = in_data_i.last_item;

  always_comb begin
    high_nibble_d = high_nibble_q;
    pending_d     = pending_q;
    held_d        = held_q;
    count_d       = count_q;
    discard_d     = discard_q;
    job_push_o    = 1'b0;
    job_o         = '0;
    job_o.status  = ST_OK;
    job_o.last    = last;

    if (accept) begin
      if (discard_q) begin
        if (last) begin
          discard_d     = 1'b0;
          high_nibble_d = '0;
          pending_d     = 1'b0;
          held_d        = '0;
          count_d       = '0;
        end
      end else if (nib[4]) begin
        job_push_o    = 1'b1;
        job_o.is_err  = 1'b1;
        job_o.status  = ST_BAD_CHAR;
        high_nibble_d = '0;
        pending_d     = 1'b0;
        held_d        = '0;
        count_d       = '0;
        discard_d     = !last;
      end else if (!pending_q) begin
        if (last) begin
          job_push_o    = 1'b1;
          job_o.is_err  = 1'b1;
          job_o.status  = ST_ODD_LEN;
          held_d        = '0;
          count_d       = '0;
        end else begin
          high_nibble_d = nib[3:0];
          pending_d     = 1'b1;
        end
      end else begin
        high_nibble_d = '0;
        pending_d     = 1'b0;
        if (count_q >= 2'd2) begin
          // full group of three bytes
          job_push_o = 1'b1;
          job_o.word = {held_q, byte_val};
          job_o.pad  = 2'd0;
          held_d     = '0;
          count_d    = '0;
        end else if (last) begin
          job_push_o = 1'b1;
          if (count_q == 2'd0) begin
            job_o.word = {byte_val, 16'h0000};
            job_o.pad  = 2'd2;
          end else begin
            job_o.word = {held_q[7:0], byte_val, 8'h00};
            job_o.pad  = 2'd1;
          end
          held_d  = '0;
          count_d = '0;
        end else begin
          held_d  = {held_q[7:0], byte_val};
          count_d = count_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_nibble_q <= '0;
      pending_q     <= 1'b0;
      held_q        <= '0;
      count_q       <= '0;
      discard_q     <= 1'b0;
    end else begin
      high_nibble_q <= high_nibble_d;
      pending_q     <= pending_d;
      held_q        <= held_d;
      count_q       <= count_d;
      discard_q     <= discard_d;
    end
  end

endmodule
`default_nettype wire

[sv/h2b64_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2b64_fifo: job queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module h2b64_fifo
  import h2b64_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t wdata_i,
  input  wire logic pop_i,
  output job_t      rdata_o,
  output logic      valid_o,
  output logic      full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/h2b64_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2b64_back: result issue
// Walks each job one char per unstalled cycle into a registered output stage.
// ----------------------------------------------------------------------------
module h2b64_back
  import h2b64_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_data_o
);

  job_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       slot_free;
  logic       advance;
  logic       final_char;
  logic [5:0] sextet;
  out_item_t  next_item;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign advance    = cur_valid_q && slot_free;
  assign final_char = cur_q.is_err || (idx_q == 2'd3);
  assign job_pop_o  = job_valid_i && (!cur_valid_q || (advance && final_char));

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.word[23:18];
      2'd1:    sextet = cur_q.word[17:12];
      2'd2:    sextet = cur_q.word[11:6];
      default: sextet = cur_q.word[5:0];
    endcase
  end

  always_comb begin
    next_item = '0;
    if (cur_q.is_err) begin
      next_item.out_char   = 8'h00;
      next_item.status     = cur_q.status;
      next_item.end_of_run = 1'b1;
    end else begin
      // characters past the real ones are padding
      if ({1'b0, idx_q} < (3'd4 - {1'b0, cur_q.pad})) begin
        next_item.out_char = sextet_char(sextet);
      end else begin
        next_item.out_char = ChPad;
      end
      next_item.status     = ST_OK;
      next_item.end_of_run = (idx_q == 2'd3) && cur_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_q <= job_i;
    end
    if (slot_free) begin
      out_q <= next_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (advance && final_char) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else if (advance) begin
        idx_q <= idx_q + 2'd1;
      end
      if (slot_free) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[tb/sv/hex_to_base64_stream_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_to_base64_stream_chk: result checker for the hex to base64 stream
// Watches both channels. For every hex character it accepts, it works out the
// base64 characters owed and queues them. Each output transfer is compared
// field by field against the oldest queued character.
// ----------------------------------------------------------------------------
module hex_to_base64_stream_chk
  import h2b64_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        mismatch_cnt_o,
  output int        chars_owed_o,
  output int        hex_in_cnt_o,
  output int        chars_out_cnt_o,
  output int        err_out_cnt_o
);

  localparam int MaxReports = 10;

  // Converter state as seen from outside
  logic [3:0]  hi_nib;
  logic        nib_held;
  logic [15:0] grp_bytes;
  logic [1:0]  grp_cnt;
  logic        dropping;

  out_item_t   owed_chars[$];

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    case (c) inside
      [8'h30:8'h39]: return {1'b0, 4'(c - 8'h30)};
      [8'h41:8'h46]: return {1'b0, 4'(c - 8'h37)};
      [8'h61:8'h66]: return {1'b0, 4'(c - 8'h57)};
      default:       return 5'h10;
    endcase
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v <= 6'd25) return 8'h41 + 8'(v);
    if (v <= 6'd51) return 8'h61 + 8'(v - 6'd26);
    if (v <= 6'd61) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return 8'h2b;
    return 8'h2f;
  endfunction

  task automatic owe_char(input logic [7:0] ch, input status_e st, input logic eor);
    out_item_t e;
    e.out_char   = ch;
    e.status     = st;
    e.end_of_run = eor;
    owed_chars.push_back(e);
  endtask

  task automatic clear_group();
    hi_nib    = '0;
    nib_held  = 1'b0;
    grp_bytes = '0;
    grp_cnt   = '0;
  endtask

  // Four characters from a 24-bit group; slots past n_real are padding.
  task automatic owe_quad(input logic [23:0] word, input int n_real, input logic last);
    logic [7:0] ch;
    for (int k = 0; k < 4; k++) begin
      ch = (k < n_real) ? b64_char(word[23 - 6 * k -: 6]) : ChPad;
      owe_char(ch, ST_OK, (k == 3) && last);
    end
  endtask

  task automatic predict_hex(input in_item_t it);
    logic [4:0] d;
    logic [7:0] b;
    if (dropping) begin
      if (it.last_item) begin
        dropping = 1'b0;
        clear_group();
      end
      return;
    end
    d = hex_val(it.hex_char);
    if (d[4]) begin
      owe_char(8'h00, ST_BAD_CHAR, 1'b1);
      clear_group();
      dropping = !it.last_item;
      return;
    end
    if (!nib_held) begin
      if (it.last_item) begin
        owe_char(8'h00, ST_ODD_LEN, 1'b1);
        clear_group();
      end else begin
        hi_nib   = d[3:0];
        nib_held = 1'b1;
      end
      return;
    end
    b        = {hi_nib, d[3:0]};
    hi_nib   = '0;
    nib_held = 1'b0;
    if (grp_cnt >= 2'd2) begin
      owe_quad({grp_bytes, b}, 4, it.last_item);
      clear_group();
      return;
    end
    grp_bytes = {grp_bytes[7:0], b};
    grp_cnt   = grp_cnt + 2'd1;
    if (it.last_item) begin
      if (grp_cnt == 2'd1) owe_quad({grp_bytes[7:0], 16'h0}, 2, 1'b1);
      else                 owe_quad({grp_bytes, 8'h0}, 3, 1'b1);
      clear_group();
    end
  endtask

  task automatic check_char(input out_item_t got);
    out_item_t want;
    if (owed_chars.size() == 0) begin
      mismatch_cnt_o++;
      if (mismatch_cnt_o <= MaxReports)
        $display("%0t: unexpected result char=%02h status=%0d eor=%0b", $realtime,
                 got.out_char, got.status, got.end_of_run);
      return;
    end
    want = owed_chars.pop_front();
    if (got.out_char != want.out_char || got.status != want.status ||
        got.end_of_run != want.end_of_run) begin
      mismatch_cnt_o++;
      if (mismatch_cnt_o <= MaxReports)
        $display("%0t: result %0d exp char=%02h status=%0d eor=%0b, %s",
                 $realtime, chars_out_cnt_o, want.out_char, want.status, want.end_of_run,
                 $sformatf("got char=%02h status=%0d eor=%0b",
                           got.out_char, got.status, got.end_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_group();
      dropping = 1'b0;
      owed_chars.delete();
      mismatch_cnt_o  = 0;
      hex_in_cnt_o    = 0;
      chars_out_cnt_o = 0;
      err_out_cnt_o   = 0;
    end else begin
      // results leave only after their input has passed the queue, so check first
      if (out_valid_i && out_ready_i) begin
        check_char(out_data_i);
        chars_out_cnt_o++;
        if (out_data_i.status != ST_OK) err_out_cnt_o++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_hex(in_data_i);
        hex_in_cnt_o++;
      end
    end
    chars_owed_o = owed_chars.size();
  end

endmodule

[tb/sv/hex_to_base64_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_to_base64_stream_tb: testbench top for the hex to base64 stream
// Feeds directed strings (padding, odd length, bad characters) and then
// random strings with random gaps on both channels and one long receiver
// stall. The checker beside the DUT predicts and compares every result.
// ----------------------------------------------------------------------------
module hex_to_base64_stream_tb;
  import h2b64_pkg::*;

  localparam int  HalfHigh   = 6;
  localparam int  HalfLow    = 6;
  localparam int  ResetCyc   = 9;
  localparam int  TargetHex  = 480;
  localparam int  StallCyc   = 120;  // long receiver hold-off
  localparam int  DrainCyc   = 20;   // queue write + job load + output reg + one group
  localparam int  CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatch_cnt;
  int chars_owed;
  int hex_in_cnt;
  int chars_out_cnt;
  int err_out_cnt;

  int   cycle_cnt;
  logic burst_mode;   // no gaps on either side while set
  logic stall_req;    // asks the receiver for one long hold-off
  int   hex_counted;  // characters the DUT actually acts on
  int   strings_sent;

  hex_to_base64_stream DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  hex_to_base64_stream_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatch_cnt),
    .chars_owed_o   (chars_owed),
    .hex_in_cnt_o   (hex_in_cnt),
    .chars_out_cnt_o(chars_out_cnt),
    .err_out_cnt_o  (err_out_cnt)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #HalfHigh clk_i = 1'b1;
    #HalfLow  clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One hex character transfer. Valid drops only when a gap is drawn, so it
  // never falls and rises within one step.
  task automatic push_hex(input logic [7:0] ch, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.hex_char  <= ch;
    in_data.last_item <= last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Directed string, last marker on its final character.
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_hex(s[i], i == s.len() - 1);
    hex_counted += s.len();
    strings_sent++;
  endtask

  // Random hex string of n_chars; a bad character replaces position bad_at
  // (negative for none). Characters after it are dropped by the DUT and
  // are not counted.
  task automatic push_random_run(input int n_chars, input int bad_at);
    int         v;
    logic [7:0] ch;
    for (int i = 0; i < n_chars; i++) begin
      if (i == bad_at) begin
        ch = 8'($urandom_range(0, 255));
        // flip into the upper half if it happened to be a digit
        if (ch inside {[ChZero:ChNine], [ChUpA:ChUpF], [ChLoA:ChLoF]}) ch ^= 8'h80;
      end else begin
        v  = $urandom_range(0, 15);
        ch = (v < 10) ? ChZero + 8'(v)
                      : ($urandom_range(0, 1) ? ChLoA : ChUpA) + 8'(v - 10);
      end
      push_hex(ch, i == n_chars - 1);
      if (bad_at < 0 || i <= bad_at) hex_counted++;
    end
    strings_sent++;
  endtask

  // Receiver: random ready gaps, stretches without gaps, one long stall.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (StallCyc) @(posedge clk_i);
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int  kind;
    int  n;
    bit  stalled_once;
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    burst_mode   = 1'b0;
    stall_req    = 1'b0;
    hex_counted  = 0;
    strings_sent = 0;
    stalled_once = 1'b0;
    repeat (ResetCyc) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    push_text("000000");   // all-zero group
    push_text("fFfFfF");   // all-ones group, mixed case
    push_text("f8");       // one byte: '+', 'A', then two pads
    push_text("9AbC");     // two bytes: one pad
    push_text("1");        // odd length, nothing held
    push_text("1g34");     // bad char mid-string, rest dropped to last
    push_hex(8'hff, 1'b1); // bad char on the last item
    hex_counted++;
    strings_sent++;
    push_hex(8'h00, 1'b0); // bad char, then a last that only ends discard
    push_hex("7", 1'b1);
    hex_counted++;
    strings_sent++;

    // --- random ---
    while (hex_counted < TargetHex) begin
      burst_mode = ((hex_counted / 80) % 3) == 1;
      if (!stalled_once && hex_counted >= 240) begin
        // full-rate sender against a stalled receiver fills the job queue
        stalled_once = 1'b1;
        burst_mode   = 1'b1;
        stall_req    = 1'b1;
        repeat (3) push_random_run(18, -1);
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n = 2 * $urandom_range(1, 9);
        push_random_run(n, -1);
      end else if (kind < 80) begin
        n = 2 * $urandom_range(0, 6) + 1;
        push_random_run(n, -1);
      end else if (kind < 94) begin
        n = $urandom_range(1, 12);
        push_random_run(n, $urandom_range(0, n - 1));
      end else begin
        // raw byte, any last marker
        push_hex(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        hex_counted++;
      end
    end
    in_valid   <= 1'b0;
    burst_mode = 1'b0;

    // let the checker take in the final transfer before looking at its queue
    @(negedge clk_i);
    while (chars_owed != 0) @(negedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    $display("Run: %0d strings, %0d hex chars accepted, %0d base64 results checked",
             strings_sent, hex_in_cnt, chars_out_cnt);
    $display("     %0d error results, one long receiver stall, %0d mismatches",
             err_out_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && chars_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
